>>> hdl/rhc_pkg.sv
`default_nettype none
package rhc_pkg;

	localparam int HUE_THR = 90;

	typedef logic [30:0] coef_t;
	typedef coef_t coef_tab_t [HUE_THR];

	typedef struct packed {
		logic              func;
		logic [7:0]        in_red;
		logic [7:0]        in_green;
		logic [7:0]        in_blue;
		logic [9:0]        in_hue;
		logic signed [7:0] in_saturation;
		logic signed [7:0] in_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [8:0] out_hue;
		logic [6:0] out_saturation;
		logic [6:0] out_value;
	} out_item_t;

	typedef logic [19:0] chan_num_t;
	typedef logic [7:0]  chan_q_t;

	typedef struct packed {
		logic            func;
		logic [8:0]      ax;
		logic [7:0]      bm;
		logic            qa;
		logic            qb;
		logic            gray;
		logic            mx0;
		logic [6:0]      lo;
		logic [15:0]     rem;
		logic [8:0]      dvs;
		logic [6:0]      quo;
		logic [15:0]     nv;
		logic [6:0]      vq;
		logic [8:0]      h;
		logic [6:0]      sat;
		logic [6:0]      vv;
		logic [2:0]      sx;
		logic [5:0]      tt;
		logic [13:0]     vs;
		logic [13:0]     vm;
		chan_num_t [2:0] ch;
		chan_q_t [2:0]   chq;
	} pipe_t;

	// threshold angles sit at k + 0.5 degrees; compare sqrt(3)*b*cos against a*sin
	function automatic coef_tab_t sin_tab_f();
		coef_tab_t tab;
		real t;
		for (int k = 0; k < HUE_THR; k++) begin
			t = (k + 0.5) * 3.14159265358979323846 / 180.0;
			tab[k] = coef_t'($rtoi($sin(t) * 1073741824.0 + 0.5));
		end
		return tab;
	endfunction

	function automatic coef_tab_t csq_tab_f();
		coef_tab_t tab;
		real t;
		for (int k = 0; k < HUE_THR; k++) begin
			t = (k + 0.5) * 3.14159265358979323846 / 180.0;
			tab[k] = coef_t'($rtoi($sqrt(3.0) * $cos(t) * 1073741824.0 + 0.5));
		end
		return tab;
	endfunction

	localparam coef_tab_t SIN_TAB = sin_tab_f();
	localparam coef_tab_t CSQ_TAB = csq_tab_f();

endpackage
`default_nettype wire

>>> hdl/rhc_if.sv
`default_nettype none
interface rhc_in_if
	import rhc_pkg::*;
	();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rhc_out_if
	import rhc_pkg::*;
	();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/rhc_search_step.sv
`default_nettype none
module rhc_search_step
	import rhc_pkg::*;
#(
	parameter int BIT = 64
) (
	input  wire pipe_t din,
	output pipe_t      dout
);

	localparam int SH = $clog2(BIT);

	logic [7:0]  top;
	logic [6:0]  k;
	logic        in_rng;
	logic [39:0] prod_a;
	logic [39:0] prod_b;
	logic [16:0] dsh;
	logic [16:0] rem_w;

	always_comb begin
		top    = {1'b0, din.lo} + 8'(BIT);
		in_rng = top <= 8'(HUE_THR);
		k      = in_rng ? 7'(top - 8'd1) : 7'd0;
		prod_a = 40'(din.ax) * 40'(SIN_TAB[k]);
		prod_b = 40'(din.bm) * 40'(CSQ_TAB[k]);
		dsh    = 17'(din.dvs) << SH;
		rem_w  = {1'b0, din.rem};
		dout   = din;
		if (in_rng && prod_b > prod_a) begin
			dout.lo = 7'(top);
		end
		if (rem_w >= dsh) begin
			dout.rem = 16'(rem_w - dsh);
			dout.quo = din.quo | (7'd1 << SH);
		end
	end

endmodule
`default_nettype wire

>>> hdl/rgb_hsv_color_converter.sv
// Color converter, RGB to HSV or HSV to RGB, selected per transaction by func.
// Input channel rx carries one color item; output channel tx returns one
// result item for each accepted input, in order. Fields not used by the
// chosen direction come back as zero.
// Throughput: one transaction per clock. The pipeline has eight register
// stages; the hue angle is found by a seven-step binary search over the
// half-degree thresholds, one step per stage, while saturation divides by
// one restoring quotient bit per stage alongside it.
// Stalls: while tx holds valid and its ready is low, the whole pipeline
// holds and rx.ready drops; no transaction is lost or repeated. Bubbles in
// flight are not squeezed out.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty.
`default_nettype none
module rgb_hsv_color_converter
	import rhc_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	rhc_in_if.sink    rx,
	rhc_out_if.source tx
);

	localparam int NSTG = 8;

	logic  adv;
	logic  v_s  [1:NSTG];
	pipe_t p_s  [1:NSTG];
	pipe_t nx   [1:NSTG];
	pipe_t srch [2:NSTG];

	assign adv      = !v_s[NSTG] || tx.ready;
	assign rx.ready = adv;

	logic [7:0]         mx;
	logic [7:0]         mn;
	logic signed [10:0] a_w;
	logic signed [8:0]  b_w;

	always_comb begin
		mx  = rx.data.in_red > rx.data.in_green ? rx.data.in_red : rx.data.in_green;
		mn  = rx.data.in_red < rx.data.in_green ? rx.data.in_red : rx.data.in_green;
		if (rx.data.in_blue > mx) begin
			mx = rx.data.in_blue;
		end
		if (rx.data.in_blue < mn) begin
			mn = rx.data.in_blue;
		end
		a_w = 11'sd2 * $signed({3'b0, rx.data.in_red}) - $signed({3'b0, rx.data.in_green})
			- $signed({3'b0, rx.data.in_blue});
		b_w = $signed({1'b0, rx.data.in_green}) - $signed({1'b0, rx.data.in_blue});

		nx[1]      = '0;
		nx[1].func = rx.data.func;
		nx[1].qa   = a_w < 0;
		nx[1].qb   = b_w < 0;
		nx[1].ax   = a_w < 0 ? 9'(-a_w) : 9'(a_w);
		nx[1].bm   = b_w < 0 ? 8'(-b_w) : 8'(b_w);
		nx[1].gray = a_w == 0 && b_w == 0;
		nx[1].mx0  = mx == 8'd0;
		nx[1].rem  = 16'(16'd200 * 16'(mx - mn) + 16'(mx));
		nx[1].dvs  = {mx, 1'b0};
		nx[1].nv   = 16'(16'd200 * 16'(mx) + 16'd255);

		if (rx.data.in_hue >= 10'd720) begin
			nx[1].h = 9'(rx.data.in_hue - 10'd720);
		end else if (rx.data.in_hue >= 10'd360) begin
			nx[1].h = 9'(rx.data.in_hue - 10'd360);
		end else begin
			nx[1].h = 9'(rx.data.in_hue);
		end

		if (rx.data.in_saturation < 0) begin
			nx[1].sat = 7'd0;
		end else if (rx.data.in_saturation > 8'sd100) begin
			nx[1].sat = 7'd100;
		end else begin
			nx[1].sat = 7'(rx.data.in_saturation);
		end

		if (rx.data.in_value < 0) begin
			nx[1].vv = 7'd0;
		end else if (rx.data.in_value > 8'sd100) begin
			nx[1].vv = 7'd100;
		end else begin
			nx[1].vv = 7'(rx.data.in_value);
		end
	end

	for (genvar i = 2; i <= NSTG; i++) begin : g_stg
		rhc_search_step #(
			.BIT(1 << (NSTG - i))
		) u_step (
			.din (p_s[i-1]),
			.dout(srch[i])
		);

		logic [29:0] vprod;
		logic [16:0] vrem;
		logic [19:0] c_w;
		logic [19:0] x_w;
		logic [19:0] m_w;
		logic [19:0] sel_w [3];
		logic [8:0]  off;

		always_comb begin
			nx[i]    = srch[i];
			vprod    = '0;
			vrem     = '0;
			c_w      = '0;
			x_w      = '0;
			m_w      = '0;
			sel_w[0] = '0;
			sel_w[1] = '0;
			sel_w[2] = '0;
			off      = '0;
			if (i == 2) begin
				priority if (p_s[i-1].h >= 9'd300) nx[i].sx = 3'd5;
				else if (p_s[i-1].h >= 9'd240) nx[i].sx = 3'd4;
				else if (p_s[i-1].h >= 9'd180) nx[i].sx = 3'd3;
				else if (p_s[i-1].h >= 9'd120) nx[i].sx = 3'd2;
				else if (p_s[i-1].h >= 9'd60) nx[i].sx = 3'd1;
				else nx[i].sx = 3'd0;
				off      = 9'(p_s[i-1].h - 9'(nx[i].sx) * 9'd60);
				nx[i].tt = nx[i].sx[0] ? 6'(9'd60 - off) : 6'(off);
				nx[i].vs = 14'(p_s[i-1].vv) * 14'(p_s[i-1].sat);
				nx[i].vm = 14'(p_s[i-1].vv) * 14'(7'd100 - p_s[i-1].sat);
				vprod    = 30'(p_s[i-1].nv) * 30'd8224;
				nx[i].vq = 7'(vprod >> 22);
			end
			if (i == 3) begin
				vrem = 17'(p_s[i-1].nv) - 17'(p_s[i-1].vq) * 17'd510;
				if (vrem >= 17'd510) begin
					nx[i].vq = p_s[i-1].vq + 7'd1;
				end
				c_w = 20'(p_s[i-1].vs) * 20'd60;
				x_w = 20'(p_s[i-1].vs) * 20'(p_s[i-1].tt);
				m_w = 20'(p_s[i-1].vm) * 20'd60;
				unique case (p_s[i-1].sx)
					3'd0: begin sel_w[0] = c_w; sel_w[1] = x_w; sel_w[2] = '0; end
					3'd1: begin sel_w[0] = x_w; sel_w[1] = c_w; sel_w[2] = '0; end
					3'd2: begin sel_w[0] = '0; sel_w[1] = c_w; sel_w[2] = x_w; end
					3'd3: begin sel_w[0] = '0; sel_w[1] = x_w; sel_w[2] = c_w; end
					3'd4: begin sel_w[0] = x_w; sel_w[1] = '0; sel_w[2] = c_w; end
					default: begin sel_w[0] = c_w; sel_w[1] = '0; sel_w[2] = x_w; end
				endcase
				for (int j = 0; j < 3; j++) begin
					nx[i].ch[j] = 20'(sel_w[j] + m_w);
				end
			end
			if (i == 4) begin
				for (int j = 0; j < 3; j++) begin
					nx[i].ch[j] = 20'((25'(p_s[i-1].ch[j]) * 25'd17 + 25'd20000) >> 6);
				end
			end
			if (i == 5) begin
				for (int j = 0; j < 3; j++) begin
					nx[i].chq[j] = 8'((36'(p_s[i-1].ch[j]) * 36'd107374) >> 26);
				end
			end
			if (i == 6) begin
				for (int j = 0; j < 3; j++) begin
					if (p_s[i-1].ch[j] - 20'(p_s[i-1].chq[j]) * 20'd625 >= 20'd625) begin
						nx[i].chq[j] = p_s[i-1].chq[j] + 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NSTG; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s[1] <= rx.valid;
			for (int i = 2; i <= NSTG; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 1; i <= NSTG; i++) begin
				p_s[i] <= nx[i];
			end
		end
	end

	pipe_t      fin;
	logic [8:0] hue_w;

	always_comb begin
		fin = p_s[NSTG];
		priority if (fin.gray) hue_w = 9'd0;
		else if (!fin.qb && !fin.qa) hue_w = 9'(fin.lo);
		else if (!fin.qb) hue_w = 9'd180 - 9'(fin.lo);
		else if (fin.qa) hue_w = 9'd180 + 9'(fin.lo);
		else hue_w = 9'd360 - 9'(fin.lo);

		tx.valid = v_s[NSTG];
		tx.data  = '0;
		if (fin.func) begin
			tx.data.out_red   = fin.chq[0];
			tx.data.out_green = fin.chq[1];
			tx.data.out_blue  = fin.chq[2];
		end else begin
			tx.data.out_hue        = hue_w;
			tx.data.out_saturation = fin.mx0 ? 7'd0 : fin.quo;
			tx.data.out_value      = fin.vq;
		end
	end

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NSTG] && !fin.func |->
			tx.data.out_hue <= 9'd360 && tx.data.out_saturation <= 7'd100
			&& tx.data.out_value <= 7'd100)
		else $error("hsv result out of range");

	a_lo: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NSTG] |-> fin.lo <= 7'(HUE_THR))
		else $error("hue search index past last threshold");

	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NSTG] && !fin.func && !fin.mx0 |-> {1'b0, fin.rem} < 17'(fin.dvs))
		else $error("saturation remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[NSTG] && !tx.ready |=> v_s[NSTG] && $stable(fin))
		else $error("output stage moved while stalled");

endmodule
`default_nettype wire
